@@ sv/jkv_pkg.sv @@
// Shared constants, codes and types of the JSON key/value extractor.
package jkv_pkg;

   localparam int MAX_KEY_CHARS_DEF = 16;
   localparam int KEY_CHARS_FULL    = 16;
   localparam int KEY_BITS_W        = 8 * KEY_CHARS_FULL;
   localparam int KEY_IDX_W         = 4;
   localparam int KEY_LEN_W         = 5;
   localparam int EMIT_W            = 16;
   localparam int STR_CAP_W         = 16;
   localparam int ARR_CAP_W         = 11;
   localparam int MODE_W            = 2;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 64;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_SECOND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_MODE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STR_CAP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARR_CAP    = 3'd5;

   localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RST = 5'd1;
   localparam logic [MODE_W-1:0]    VALUE_MODE_RST = 2'd0;
   localparam logic [STR_CAP_W-1:0] STR_CAP_RST    = 16'd256;
   localparam logic [ARR_CAP_W-1:0] ARR_CAP_RST    = 11'd16;

   localparam logic [MODE_W-1:0] MODE_STRING = 2'd0;
   localparam logic [MODE_W-1:0] MODE_U32    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ARRAY  = 2'd2;

   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_ELEM  = 2'd1;
   localparam logic [1:0] KIND_FINAL = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOKEY     = 3'd1;
   localparam logic [2:0] ST_MALFORMED = 3'd2;
   localparam logic [2:0] ST_OVERFLOW  = 3'd3;
   localparam logic [2:0] ST_CAPACITY  = 3'd4;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [2:0]  status;
      logic        run_end;
   } jkv_result_type;

   typedef struct packed {
      logic shift;
      logic restart;
      logic clear;
   } jkv_win_ctl_type;

   typedef struct packed {
      logic cont;
      logic fresh;
   } jkv_win_hit_type;

endpackage

@@ sv/jkv_window.sv @@
// Sliding byte window and quoted-key match.
module jkv_window #(
   parameter int MaxKeyChars = jkv_pkg::MAX_KEY_CHARS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  jkv_pkg::jkv_win_ctl_type        win_ctl,
   input  logic [7:0]                      data_byte,
   input  logic [jkv_pkg::KEY_BITS_W-1:0]  key_bits,
   input  logic [jkv_pkg::KEY_LEN_W-1:0]   key_length,
   output jkv_pkg::jkv_win_hit_type        win_hit
);
   import jkv_pkg::*;

   localparam int WinDepth = MaxKeyChars + 2;
   localparam int FillW    = $clog2(WinDepth + 1);

   logic [7:0]           win_ff [WinDepth];
   logic [7:0]           win_in [WinDepth];
   logic [FillW-1:0]     fill_ff;
   logic [FillW-1:0]     fill_in;
   logic [FillW-1:0]     fill_cont;
   logic [KEY_LEN_W-1:0] kc;
   logic [WinDepth-1:0]  pos_ok;
   logic                 match;
   logic                 hit_sel;

   assign kc = (key_length > KEY_LEN_W'(MaxKeyChars)) ? KEY_LEN_W'(MaxKeyChars) : key_length;

   // Each tap is checked against the pattern "key" aligned to the newest byte.
   always_comb begin
      logic [KEY_LEN_W-1:0] span;
      logic [KEY_LEN_W-1:0] idx;
      logic [7:0]           want;
      for (int j = 0; j < WinDepth - 1; j++) begin
         win_in[j] = win_ff[j+1];
      end
      win_in[WinDepth-1] = data_byte;
      for (int j = 0; j < WinDepth; j++) begin
         span = KEY_LEN_W'(WinDepth - 1 - j);
         idx  = kc - span;
         want = key_bits[8*idx[KEY_IDX_W-1:0] +: 8];
         if (span == '0 || span == kc + 1'b1) begin
            pos_ok[j] = (win_in[j] == CH_QUOTE);
         end else if (span <= kc) begin
            pos_ok[j] = (win_in[j] == want);
         end else begin
            pos_ok[j] = 1'b1;
         end
      end
   end

   assign match     = (kc != '0) && (&pos_ok);
   assign fill_cont = (fill_ff == FillW'(WinDepth)) ? fill_ff : fill_ff + 1'b1;

   assign win_hit.cont  = match && (int'(fill_cont) >= int'(kc) + 2);
   assign win_hit.fresh = match && (int'(kc) + 2 <= 1);
   assign hit_sel       = win_ctl.restart ? win_hit.fresh : win_hit.cont;

   always_comb begin
      fill_in = fill_ff;
      if (win_ctl.clear) begin
         fill_in = '0;
      end else if (win_ctl.shift) begin
         if (hit_sel) begin
            fill_in = '0;
         end else if (win_ctl.restart) begin
            fill_in = FillW'(1);
         end else begin
            fill_in = fill_cont;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_ctl.shift) begin
         win_ff <= win_in;
      end
   end

endmodule

@@ sv/jkv_parse.sv @@
// Value parser: phase tracking, string decode, decimal accumulate, result build.
module jkv_parse (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [7:0]                      data_byte,
   input  logic                            last_byte,
   input  jkv_pkg::jkv_win_hit_type        win_hit,
   input  logic [jkv_pkg::MODE_W-1:0]      value_mode,
   input  logic [jkv_pkg::STR_CAP_W-1:0]   string_capacity,
   input  logic [jkv_pkg::ARR_CAP_W-1:0]   array_capacity,
   output jkv_pkg::jkv_win_ctl_type        win_ctl,
   output logic [1:0]                      push_count,
   output jkv_pkg::jkv_result_type         push_res0,
   output jkv_pkg::jkv_result_type         push_res1
);
   import jkv_pkg::*;

   typedef enum logic [3:0] {
      PH_SEARCH,
      PH_AFTER_KEY,
      PH_AFTER_COLON,
      PH_STR,
      PH_U32,
      PH_ARR_OPEN,
      PH_ARR_NUM,
      PH_ARR_AFTER,
      PH_ARR_ELEM
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [31:0]       acc_ff, acc_in;
   logic              ovf_ff, ovf_in;
   logic              esc_ff, esc_in;
   logic [EMIT_W-1:0] cnt_ff, cnt_in;
   logic              fin_ff, fin_in;
   jkv_win_ctl_type   wctl;
   jkv_result_type    res [2];
   logic [1:0]        nres;

   function automatic logic is_ws(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   // acc*10 + digit, saturating; top bit flags overflow.
   function automatic logic [32:0] acc_step(logic [31:0] a, logic [7:0] b);
      logic [35:0] v;
      v = {4'd0, a} * 36'd10 + 36'(b - CH_ZERO);
      if (v[35:32] != '0) begin
         return {1'b1, 32'hFFFF_FFFF};
      end
      return {1'b0, v[31:0]};
   endfunction

   function automatic jkv_result_type mk_res(logic [1:0] k, logic [31:0] v, logic [2:0] s,
                                             logic e);
      jkv_result_type r;
      r.kind    = k;
      r.value   = v;
      r.status  = s;
      r.run_end = e;
      return r;
   endfunction

   always_comb begin
      logic        done;
      logic        str_char;
      logic        run_after;
      logic [7:0]  ch;
      logic [32:0] st;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      esc_in    = esc_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      wctl      = '0;
      res[0]    = '0;
      res[1]    = '0;
      nres      = '0;
      done      = 1'b0;
      str_char  = 1'b0;
      run_after = 1'b0;
      ch        = data_byte;
      st        = acc_step(acc_ff, data_byte);
      if (!fin_ff) begin
         case (phase_ff)
            PH_SEARCH: begin
               wctl.shift = 1'b1;
               if (win_hit.cont) begin
                  phase_in = PH_AFTER_KEY;
               end
            end
            PH_AFTER_KEY: begin
               if (!is_ws(data_byte)) begin
                  if (data_byte == CH_COLON) begin
                     phase_in = PH_AFTER_COLON;
                  end else begin
                     phase_in     = win_hit.fresh ? PH_AFTER_KEY : PH_SEARCH;
                     wctl.shift   = 1'b1;
                     wctl.restart = 1'b1;
                  end
               end
            end
            PH_AFTER_COLON: begin
               if (!is_ws(data_byte)) begin
                  cnt_in = '0;
                  esc_in = 1'b0;
                  if (value_mode == MODE_STRING && data_byte == CH_QUOTE) begin
                     phase_in = PH_STR;
                  end else if (value_mode == MODE_U32 && is_digit(data_byte)) begin
                     phase_in = PH_U32;
                     acc_in   = 32'(data_byte - CH_ZERO);
                     ovf_in   = 1'b0;
                  end else if (value_mode == MODE_ARRAY && data_byte == CH_LBRACK) begin
                     phase_in = PH_ARR_OPEN;
                  end else begin
                     done         = 1'b1;
                     res[nres[0]] = mk_res(KIND_FINAL, '0, ST_MALFORMED, 1'b1);
                     nres         = nres + 2'd1;
                  end
               end
            end
            PH_STR: begin
               if (esc_ff) begin
                  esc_in   = 1'b0;
                  str_char = 1'b1;
                  if (data_byte == CH_N) begin
                     ch = CH_LF;
                  end else if (data_byte == CH_T) begin
                     ch = CH_TAB;
                  end else if (data_byte == CH_R) begin
                     ch = CH_CR;
                  end
               end else if (data_byte == CH_BSLASH) begin
                  esc_in = 1'b1;
               end else if (data_byte == CH_QUOTE) begin
                  done         = 1'b1;
                  res[nres[0]] = mk_res(KIND_FINAL, 32'(cnt_ff), ST_OK, 1'b1);
                  nres         = nres + 2'd1;
               end else begin
                  str_char = 1'b1;
               end
            end
            PH_U32: begin
               if (is_digit(data_byte)) begin
                  acc_in = st[31:0];
                  ovf_in = ovf_ff | st[32];
               end else begin
                  done         = 1'b1;
                  res[nres[0]] = ovf_ff ? mk_res(KIND_FINAL, '0, ST_OVERFLOW, 1'b1)
                                        : mk_res(KIND_FINAL, acc_ff, ST_OK, 1'b1);
                  nres         = nres + 2'd1;
               end
            end
            PH_ARR_OPEN, PH_ARR_ELEM: begin
               if (!is_ws(data_byte)) begin
                  if (phase_ff == PH_ARR_OPEN && data_byte == CH_RBRACK) begin
                     done         = 1'b1;
                     res[nres[0]] = mk_res(KIND_FINAL, '0, ST_OK, 1'b1);
                     nres         = nres + 2'd1;
                  end else if (is_digit(data_byte)) begin
                     phase_in = PH_ARR_NUM;
                     acc_in   = 32'(data_byte - CH_ZERO);
                     ovf_in   = 1'b0;
                  end else begin
                     done         = 1'b1;
                     res[nres[0]] = mk_res(KIND_FINAL, '0, ST_MALFORMED, 1'b1);
                     nres         = nres + 2'd1;
                  end
               end
            end
            PH_ARR_NUM: begin
               if (is_digit(data_byte)) begin
                  acc_in = st[31:0];
                  ovf_in = ovf_ff | st[32];
               end else if (ovf_ff) begin
                  done         = 1'b1;
                  res[nres[0]] = mk_res(KIND_FINAL, '0, ST_OVERFLOW, 1'b1);
                  nres         = nres + 2'd1;
               end else if (cnt_ff >= EMIT_W'(array_capacity)) begin
                  done         = 1'b1;
                  res[nres[0]] = mk_res(KIND_FINAL, '0, ST_CAPACITY, 1'b1);
                  nres         = nres + 2'd1;
               end else begin
                  cnt_in       = cnt_ff + 1'b1;
                  phase_in     = PH_ARR_AFTER;
                  res[nres[0]] = mk_res(KIND_ELEM, acc_ff, ST_OK, 1'b0);
                  nres         = nres + 2'd1;
                  run_after    = 1'b1;
               end
            end
            PH_ARR_AFTER: begin
               run_after = 1'b1;
            end
            default: begin
               done         = 1'b1;
               res[nres[0]] = mk_res(KIND_FINAL, '0, ST_MALFORMED, 1'b1);
               nres         = nres + 2'd1;
            end
         endcase

         if (str_char) begin
            if ({1'b0, cnt_in} + 17'd1 >= {1'b0, string_capacity}) begin
               done         = 1'b1;
               res[nres[0]] = mk_res(KIND_FINAL, '0, ST_CAPACITY, 1'b1);
            end else begin
               cnt_in       = cnt_in + 1'b1;
               res[nres[0]] = mk_res(KIND_CHAR, 32'(ch), ST_OK, 1'b0);
            end
            nres = nres + 2'd1;
         end

         if (run_after && !is_ws(data_byte)) begin
            if (data_byte == CH_COMMA) begin
               phase_in = PH_ARR_ELEM;
            end else begin
               done = 1'b1;
               if (data_byte == CH_RBRACK) begin
                  res[nres[0]] = mk_res(KIND_FINAL, 32'(cnt_in), ST_OK, 1'b1);
               end else begin
                  res[nres[0]] = mk_res(KIND_FINAL, '0, ST_MALFORMED, 1'b1);
               end
               nres = nres + 2'd1;
            end
         end

         // End of body with the value still open.
         if (last_byte && !done) begin
            case (phase_in)
               PH_SEARCH, PH_AFTER_KEY, PH_AFTER_COLON: begin
                  res[nres[0]] = mk_res(KIND_FINAL, '0, ST_NOKEY, 1'b1);
               end
               PH_STR: begin
                  if (esc_in && {1'b0, cnt_in} + 17'd1 >= {1'b0, string_capacity}) begin
                     res[nres[0]] = mk_res(KIND_FINAL, '0, ST_CAPACITY, 1'b1);
                  end else begin
                     if (esc_in) begin
                        res[nres[0]] = mk_res(KIND_CHAR, 32'(CH_BSLASH), ST_OK, 1'b0);
                        nres         = nres + 2'd1;
                     end
                     res[nres[0]] = mk_res(KIND_FINAL, '0, ST_MALFORMED, 1'b1);
                  end
               end
               PH_U32: begin
                  res[nres[0]] = ovf_in ? mk_res(KIND_FINAL, '0, ST_OVERFLOW, 1'b1)
                                        : mk_res(KIND_FINAL, acc_in, ST_OK, 1'b1);
               end
               PH_ARR_NUM: begin
                  if (ovf_in) begin
                     res[nres[0]] = mk_res(KIND_FINAL, '0, ST_OVERFLOW, 1'b1);
                  end else if (cnt_in >= EMIT_W'(array_capacity)) begin
                     res[nres[0]] = mk_res(KIND_FINAL, '0, ST_CAPACITY, 1'b1);
                  end else begin
                     res[nres[0]] = mk_res(KIND_ELEM, acc_in, ST_OK, 1'b0);
                     nres         = nres + 2'd1;
                     res[nres[0]] = mk_res(KIND_FINAL, '0, ST_MALFORMED, 1'b1);
                  end
               end
               default: begin
                  res[nres[0]] = mk_res(KIND_FINAL, '0, ST_MALFORMED, 1'b1);
               end
            endcase
            nres = nres + 2'd1;
         end
      end

      if (last_byte) begin
         phase_in   = PH_SEARCH;
         acc_in     = '0;
         ovf_in     = 1'b0;
         esc_in     = 1'b0;
         cnt_in     = '0;
         fin_in     = 1'b0;
         wctl.clear = 1'b1;
      end else if (done) begin
         fin_in = 1'b1;
      end
   end

   assign win_ctl    = step ? wctl : '0;
   assign push_count = step ? nres : 2'd0;
   assign push_res0  = res[0];
   assign push_res1  = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         esc_ff   <= 1'b0;
         cnt_ff   <= '0;
         fin_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         esc_ff   <= esc_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

@@ sv/jkv_rsp_queue.sv @@
// Result queue: takes up to two items a cycle, hands out one while rsp_stall is low.
module jkv_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_count,
   input  jkv_pkg::jkv_result_type push_res0,
   input  jkv_pkg::jkv_result_type push_res1,
   output logic                    room2,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output jkv_pkg::jkv_result_type head
);
   import jkv_pkg::*;

   localparam int AddrW = $clog2(QUEUE_DEPTH);
   localparam int CntW  = $clog2(QUEUE_DEPTH + 1);

   jkv_result_type   mem_ff [QUEUE_DEPTH];
   logic [AddrW-1:0] wr_ff, wr_in;
   logic [AddrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             pop;

   assign rsp_valid = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room2     = (int'(cnt_ff) <= QUEUE_DEPTH - 2);

   assign wr_in  = wr_ff + AddrW'(push_count);
   assign rd_in  = rd_ff + AddrW'(pop);
   assign cnt_in = cnt_ff + CntW'(push_count) - CntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ff] <= push_res0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ff + 1'b1] <= push_res1;
      end
   end

endmodule

@@ sv/json_key_value_extractor_core.sv @@
// Top level of the JSON key/value extractor: configuration, input register, parser, queue.
//
// Takes one body byte per cycle. A byte is parsed during the cycle it sits in the input
// register, and its results (zero, one or two items) land in a four-entry result queue; the
// first result goes through the input register and the queue to the output. The queue drains
// one item per cycle; a new byte is parsed only while it has two free entries, so the input
// runs at one byte per cycle as long as the result side keeps pace and bytes yield at most
// one item. Configuration writes are always ready and act on the next byte parsed.
module json_key_value_extractor_core #(
   parameter int MaxKeyChars = jkv_pkg::MAX_KEY_CHARS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_item_kind,
   output logic [31:0]                     rsp_item_value,
   output logic [2:0]                      rsp_result_status,
   output logic                            rsp_end_of_run,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [jkv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [jkv_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import jkv_pkg::*;

   logic [63:0]          key_first_ff;
   logic [63:0]          key_second_ff;
   logic [KEY_LEN_W-1:0] key_length_ff;
   logic [MODE_W-1:0]    value_mode_ff;
   logic [STR_CAP_W-1:0] str_cap_ff;
   logic [ARR_CAP_W-1:0] arr_cap_ff;

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic                 room2;
   logic                 step;
   logic                 load;

   jkv_win_ctl_type      win_ctl;
   jkv_win_hit_type      win_hit;
   logic [1:0]           push_count;
   jkv_result_type       push_res0;
   jkv_result_type       push_res1;
   jkv_result_type       head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_first_ff  <= '0;
         key_second_ff <= '0;
         key_length_ff <= KEY_LENGTH_RST;
         value_mode_ff <= VALUE_MODE_RST;
         str_cap_ff    <= STR_CAP_RST;
         arr_cap_ff    <= ARR_CAP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_FIRST:  key_first_ff  <= csr_write_data[63:0];
            CSR_KEY_SECOND: key_second_ff <= csr_write_data[63:0];
            CSR_KEY_LENGTH: key_length_ff <= csr_write_data[KEY_LEN_W-1:0];
            CSR_VALUE_MODE: value_mode_ff <= csr_write_data[MODE_W-1:0];
            CSR_STR_CAP:    str_cap_ff    <= csr_write_data[STR_CAP_W-1:0];
            CSR_ARR_CAP:    arr_cap_ff    <= csr_write_data[ARR_CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign step      = in_valid_ff && room2;
   assign req_stall = in_valid_ff && !room2;
   assign load      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (load) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   jkv_window #(
      .MaxKeyChars (MaxKeyChars)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .win_ctl    (win_ctl),
      .data_byte  (in_byte_ff),
      .key_bits   ({key_second_ff, key_first_ff}),
      .key_length (key_length_ff),
      .win_hit    (win_hit)
   );

   jkv_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .data_byte       (in_byte_ff),
      .last_byte       (in_last_ff),
      .win_hit         (win_hit),
      .value_mode      (value_mode_ff),
      .string_capacity (str_cap_ff),
      .array_capacity  (arr_cap_ff),
      .win_ctl         (win_ctl),
      .push_count      (push_count),
      .push_res0       (push_res0),
      .push_res1       (push_res1)
   );

   jkv_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_res0  (push_res0),
      .push_res1  (push_res1),
      .room2      (room2),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .head       (head)
   );

   assign rsp_item_kind     = head.kind;
   assign rsp_item_value    = head.value;
   assign rsp_result_status = head.status;
   assign rsp_end_of_run    = head.run_end;

endmodule

@@ sv/jkv_checker.sv @@
// Port-level checks of the extractor's result channel, bound to the top level.
module jkv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_item_kind,
   input logic [31:0] rsp_item_value,
   input logic [2:0]  rsp_result_status,
   input logic        rsp_end_of_run
);
   import jkv_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item_kind)
         && $stable(rsp_item_value) && $stable(rsp_result_status) && $stable(rsp_end_of_run))
      else $error("result item changed while stalled");

   a_end_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_end_of_run == (rsp_item_kind == KIND_FINAL)))
      else $error("end of run does not match final kind");

   a_data_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind != KIND_FINAL |-> rsp_result_status == ST_OK)
      else $error("data item carries an error status");

   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_run && rsp_result_status != ST_OK |-> rsp_item_value == '0)
      else $error("error final carries a nonzero value");

endmodule

bind json_key_value_extractor_core jkv_checker u_jkv_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_item_kind     (rsp_item_kind),
   .rsp_item_value    (rsp_item_value),
   .rsp_result_status (rsp_result_status),
   .rsp_end_of_run    (rsp_end_of_run)
);

@@ tb/tb_top.sv @@
// Self-checking bench for json_key_value_extractor_core: directed and random bodies, own parse model, stalls.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import jkv_pkg::*;

   localparam int ITEM_TARGET  = 1250;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_MAX   = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;

   typedef enum logic [3:0] {
      HUNT, KEY_SEEN, COLON_SEEN, IN_STRING, IN_NUMBER, ARR_OPEN, ARR_NUM, ARR_AFTER, ARR_NEXT
   } scan_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eob;
   } body_byte_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte = '0;
   logic                  req_last_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_item_kind;
   logic [31:0]           rsp_item_value;
   logic [2:0]            rsp_result_status;
   logic                  rsp_end_of_run;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   json_key_value_extractor_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_item_value    (rsp_item_value),
      .rsp_result_status (rsp_result_status),
      .rsp_end_of_run    (rsp_end_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   // register copy
   logic [63:0]          key_lo = '0;
   logic [63:0]          key_hi = '0;
   logic [KEY_LEN_W-1:0] key_len = KEY_LENGTH_RST;
   logic [MODE_W-1:0]    val_mode = VALUE_MODE_RST;
   logic [STR_CAP_W-1:0] str_cap = STR_CAP_RST;
   logic [ARR_CAP_W-1:0] arr_cap = ARR_CAP_RST;

   // parser state
   scan_state_type scan;
   logic [7:0]  win [18];
   int          win_fill;
   logic [31:0] acc;
   bit          acc_ovf;
   bit          esc;
   int unsigned emitted;
   bit          body_done;
   bit          step_done;

   jkv_result_type pending_results[$];
   body_byte_type  byte_feed[$];
   logic [7:0]     body_buf[$];
   bit             body_stop;
   int             bytes_sent = 0;
   int             feed_odds = 0;
   int             sink_odds = 0;
   int             feed_gap = 0;
   int             sink_gap = 0;
   int             mismatches = 0;
   int             idle_cycles = 0;

   function automatic bit is_ws(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic int key_chars();
      return (key_len > 5'd16) ? 16 : int'(key_len);
   endfunction

   function automatic logic [7:0] key_char(int i);
      return (i < 8) ? key_lo[8*i +: 8] : key_hi[8*(i-8) +: 8];
   endfunction

   function automatic void restart_body();
      scan = HUNT;
      foreach (win[i]) win[i] = '0;
      win_fill = 0;
      acc = '0;
      acc_ovf = 1'b0;
      esc = 1'b0;
      emitted = 0;
      body_done = 1'b0;
   endfunction

   function automatic void emit(logic [1:0] kind, logic [31:0] value, logic [2:0] status);
      jkv_result_type r;
      r.kind = kind;
      r.value = value;
      r.status = status;
      r.run_end = (kind == KIND_FINAL);
      pending_results.push_back(r);
      if (kind == KIND_FINAL) step_done = 1'b1;
   endfunction

   function automatic bit window_hit(logic [7:0] b);
      int k;
      int i;
      k = key_chars();
      for (i = 0; i < 17; i++) win[i] = win[i+1];
      win[17] = b;
      if (win_fill < 18) win_fill++;
      if (k == 0 || win_fill < k + 2) return 1'b0;
      if (win[17] != CH_QUOTE || win[16-k] != CH_QUOTE) return 1'b0;
      for (i = 0; i < k; i++)
         if (win[17-k+i] != key_char(i)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void accumulate(logic [7:0] b);
      logic [35:0] v;
      v = 36'(acc) * 36'd10 + 36'(b - CH_ZERO);
      if (v > 36'hFFFF_FFFF) begin
         acc_ovf = 1'b1;
         acc = '1;
      end else begin
         acc = v[31:0];
      end
   endfunction

   function automatic void start_number(logic [7:0] b, scan_state_type nxt);
      acc = '0;
      acc_ovf = 1'b0;
      accumulate(b);
      scan = nxt;
   endfunction

   function automatic void add_string_char(logic [7:0] c);
      if (emitted + 1 >= str_cap) begin
         emit(KIND_FINAL, '0, ST_CAPACITY);
      end else begin
         emitted++;
         emit(KIND_CHAR, 32'(c), ST_OK);
      end
   endfunction

   function automatic void close_element();
      if (acc_ovf) begin
         emit(KIND_FINAL, '0, ST_OVERFLOW);
      end else if (emitted >= arr_cap) begin
         emit(KIND_FINAL, '0, ST_CAPACITY);
      end else begin
         emitted++;
         scan = ARR_AFTER;
         emit(KIND_ELEM, acc, ST_OK);
      end
   endfunction

   function automatic void number_result();
      if (acc_ovf) emit(KIND_FINAL, '0, ST_OVERFLOW);
      else emit(KIND_FINAL, acc, ST_OK);
   endfunction

   function automatic void after_element(logic [7:0] b);
      if (!is_ws(b)) begin
         if (b == CH_COMMA) scan = ARR_NEXT;
         else if (b == CH_RBRACK) emit(KIND_FINAL, emitted, ST_OK);
         else emit(KIND_FINAL, '0, ST_MALFORMED);
      end
   endfunction

   function automatic void consume(logic [7:0] b);
      logic [7:0] c;
      case (scan)
         HUNT: begin
            if (window_hit(b)) begin
               scan = KEY_SEEN;
               win_fill = 0;
            end
         end
         KEY_SEEN: begin
            if (b == CH_COLON) begin
               scan = COLON_SEEN;
            end else if (!is_ws(b)) begin
               scan = HUNT;
               win_fill = 0;
               if (window_hit(b)) begin
                  scan = KEY_SEEN;
                  win_fill = 0;
               end
            end
         end
         COLON_SEEN: begin
            if (!is_ws(b)) begin
               emitted = 0;
               esc = 1'b0;
               if (val_mode == MODE_STRING && b == CH_QUOTE) scan = IN_STRING;
               else if (val_mode == MODE_U32 && is_digit(b)) start_number(b, IN_NUMBER);
               else if (val_mode == MODE_ARRAY && b == CH_LBRACK) scan = ARR_OPEN;
               else emit(KIND_FINAL, '0, ST_MALFORMED);
            end
         end
         IN_STRING: begin
            if (esc) begin
               esc = 1'b0;
               c = (b == CH_N) ? CH_LF : (b == CH_T) ? CH_TAB : (b == CH_R) ? CH_CR : b;
               add_string_char(c);
            end else if (b == CH_BSLASH) begin
               esc = 1'b1;
            end else if (b == CH_QUOTE) begin
               emit(KIND_FINAL, emitted, ST_OK);
            end else begin
               add_string_char(b);
            end
         end
         IN_NUMBER: begin
            if (is_digit(b)) accumulate(b);
            else number_result();
         end
         ARR_OPEN: begin
            if (!is_ws(b)) begin
               if (b == CH_RBRACK) emit(KIND_FINAL, '0, ST_OK);
               else if (is_digit(b)) start_number(b, ARR_NUM);
               else emit(KIND_FINAL, '0, ST_MALFORMED);
            end
         end
         ARR_NUM: begin
            if (is_digit(b)) begin
               accumulate(b);
            end else begin
               close_element();
               if (!step_done) after_element(b);
            end
         end
         ARR_AFTER: after_element(b);
         ARR_NEXT: begin
            if (!is_ws(b)) begin
               if (is_digit(b)) start_number(b, ARR_NUM);
               else emit(KIND_FINAL, '0, ST_MALFORMED);
            end
         end
         default: emit(KIND_FINAL, '0, ST_MALFORMED);
      endcase
   endfunction

   function automatic void wrap_body();
      case (scan)
         HUNT, KEY_SEEN, COLON_SEEN: emit(KIND_FINAL, '0, ST_NOKEY);
         IN_STRING: begin
            if (esc) begin
               esc = 1'b0;
               add_string_char(CH_BSLASH);
            end
            if (!step_done) emit(KIND_FINAL, '0, ST_MALFORMED);
         end
         IN_NUMBER: number_result();
         ARR_NUM: begin
            close_element();
            if (!step_done) emit(KIND_FINAL, '0, ST_MALFORMED);
         end
         default: emit(KIND_FINAL, '0, ST_MALFORMED);
      endcase
   endfunction

   function automatic void step_extractor(logic [7:0] b, logic eob);
      if (body_done) begin
         if (eob) restart_body();
      end else begin
         step_done = 1'b0;
         consume(b);
         if (eob) begin
            if (!step_done) wrap_body();
            restart_body();
         end else if (step_done) begin
            body_done = 1'b1;
         end
      end
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
         CSR_KEY_FIRST:  key_lo = data;
         CSR_KEY_SECOND: key_hi = data;
         CSR_KEY_LENGTH: key_len = data[KEY_LEN_W-1:0];
         CSR_VALUE_MODE: val_mode = data[MODE_W-1:0];
         CSR_STR_CAP:    str_cap = data[STR_CAP_W-1:0];
         CSR_ARR_CAP:    arr_cap = data[ARR_CAP_W-1:0];
         default: ;
      endcase
   endfunction

   // body text generation
   function automatic void put_byte(logic [7:0] b);
      body_buf.push_back(b);
   endfunction

   function automatic void put_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function automatic logic [7:0] ws_pick();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   function automatic void put_space();
      repeat ($urandom_range(0, 2)) put_byte(ws_pick());
   endfunction

   function automatic void put_key();
      int i;
      int k;
      k = key_chars();
      if (k == 0) put_text("id");
      for (i = 0; i < k; i++) put_byte(key_char(i));
   endfunction

   function automatic void put_number();
      case ($urandom_range(0, 9))
         0: put_text("4294967295");
         1: put_text("4294967296");
         2: repeat ($urandom_range(11, 14)) put_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
         3: put_text("0");
         4: put_text($sformatf("00%0d", $urandom_range(0, 99)));
         5: put_text($sformatf("%0d", $urandom));
         default: put_text($sformatf("%0d", $urandom_range(0, 9999)));
      endcase
   endfunction

   function automatic void put_string_value();
      int i;
      int n;
      logic [7:0] c;
      put_byte(CH_QUOTE);
      n = (str_cap < 12 && $urandom_range(0, 1) == 1) ? $urandom_range(0, str_cap + 1)
                                                      : $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0: begin
               put_byte(CH_BSLASH);
               case ($urandom_range(0, 5))
                  0: put_byte(CH_N);
                  1: put_byte(CH_T);
                  2: put_byte(CH_R);
                  3: put_byte(CH_QUOTE);
                  4: put_byte(CH_BSLASH);
                  default: put_byte(8'($urandom));
               endcase
            end
            1: begin
               c = 8'($urandom);
               put_byte((c == CH_QUOTE || c == CH_BSLASH) ? CH_SPACE : c);
            end
            default: begin
               c = 8'($urandom_range(32, 126));
               put_byte((c == CH_QUOTE || c == CH_BSLASH) ? CH_SPACE : c);
            end
         endcase
      end
      if ($urandom_range(0, 9) == 0) begin
         put_byte(CH_BSLASH);
         body_stop = 1'b1;
      end else begin
         put_byte(CH_QUOTE);
      end
   endfunction

   function automatic void put_array_value();
      int i;
      int n;
      put_byte(CH_LBRACK);
      put_space();
      n = (arr_cap < 5 && $urandom_range(0, 1) == 1) ? $urandom_range(0, arr_cap + 1)
                                                     : $urandom_range(0, 4);
      for (i = 0; i < n; i++) begin
         put_number();
         if (i == n - 1 && $urandom_range(0, 7) == 0) begin
            body_stop = 1'b1;
            return;
         end
         put_space();
         if (i < n - 1) begin
            put_byte(CH_COMMA);
            put_space();
         end
      end
      if (n > 0 && $urandom_range(0, 9) == 0) put_byte(CH_COMMA);
      put_byte(CH_RBRACK);
   endfunction

   function automatic void put_value();
      logic [MODE_W-1:0] m;
      m = val_mode;
      if (m > MODE_ARRAY || $urandom_range(0, 7) == 0) m = MODE_W'($urandom_range(0, 2));
      case (m)
         MODE_STRING: put_string_value();
         MODE_U32: begin
            put_number();
            if ($urandom_range(0, 3) == 0) body_stop = 1'b1;
         end
         default: put_array_value();
      endcase
   endfunction

   function automatic void put_decoy();
      put_byte(CH_QUOTE);
      if ($urandom_range(0, 1) == 1) put_key();
      else put_text("zz");
      put_byte(CH_QUOTE);
      put_space();
      case ($urandom_range(0, 2))
         0: put_byte(CH_COMMA);
         1: put_byte(CH_QUOTE);
         default: begin
            put_byte(CH_COLON);
            put_text("0,");
         end
      endcase
      put_space();
   endfunction

   function automatic void make_body();
      int shape;
      int cut;
      body_buf.delete();
      body_stop = 1'b0;
      shape = $urandom_range(0, 19);
      if (shape == 0) begin
         repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
      end else begin
         if ($urandom_range(0, 1) == 1) put_byte("{");
         repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(32, 126)));
         if ($urandom_range(0, 3) == 0) put_decoy();
         put_byte(CH_QUOTE);
         put_key();
         put_byte(CH_QUOTE);
         put_space();
         if ($urandom_range(0, 11) == 0) put_byte("x");
         else put_byte(CH_COLON);
         put_space();
         put_value();
         if (!body_stop) begin
            case ($urandom_range(0, 3))
               0: put_text(",\"x\":1}");
               1: repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
               default: put_byte("}");
            endcase
         end
      end
      // truncated and corrupted bodies
      if ((shape == 1 || shape == 2) && body_buf.size() > 1) begin
         cut = $urandom_range(1, body_buf.size() - 1);
         while (body_buf.size() > cut) void'(body_buf.pop_back());
      end
      if (shape == 3) body_buf[$urandom_range(0, body_buf.size() - 1)] = 8'($urandom);
   endfunction

   function automatic void send_body();
      int i;
      body_byte_type bb;
      for (i = 0; i < body_buf.size(); i++) begin
         bb.data = body_buf[i];
         bb.eob = (i == body_buf.size() - 1);
         byte_feed.push_back(bb);
      end
      bytes_sent += body_buf.size();
   endfunction

   // configuration and sequencing
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
   endtask

   task automatic program_regs(logic [KEY_LEN_W-1:0] kl, logic [63:0] klo, logic [63:0] khi,
                               logic [MODE_W-1:0] mode, logic [STR_CAP_W-1:0] scap,
                               logic [ARR_CAP_W-1:0] acap);
      if ($urandom_range(0, 3) == 0) write_reg(CSR_SPARE, {$urandom, $urandom});
      write_reg(CSR_KEY_FIRST, klo);
      write_reg(CSR_KEY_SECOND, khi);
      write_reg(CSR_KEY_LENGTH, 64'(kl));
      write_reg(CSR_VALUE_MODE, 64'(mode));
      write_reg(CSR_STR_CAP, 64'(scap));
      write_reg(CSR_ARR_CAP, 64'(acap));
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      do @(negedge clock);
      while (byte_feed.size() != 0 || req_valid || pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_odds();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 4;
         2: return 12;
         default: return 30;
      endcase
   endfunction

   task automatic random_phase(bit quiet);
      logic [63:0]          klo;
      logic [63:0]          khi;
      logic [KEY_LEN_W-1:0] kl;
      logic [MODE_W-1:0]    mode;
      logic [STR_CAP_W-1:0] scap;
      logic [ARR_CAP_W-1:0] acap;
      int                   i;
      bit                   letters;
      letters = ($urandom_range(0, 3) != 0);
      for (i = 0; i < 8; i++) begin
         klo[8*i +: 8] = letters ? 8'($urandom_range("a", "z")) : 8'($urandom);
         khi[8*i +: 8] = letters ? 8'($urandom_range("a", "z")) : 8'($urandom);
      end
      case ($urandom_range(0, 19))
         0: kl = 5'd0;
         1: kl = 5'd16;
         2: kl = 5'($urandom_range(17, 31));
         3, 4, 5: kl = 5'($urandom_range(5, 15));
         default: kl = 5'($urandom_range(1, 4));
      endcase
      mode = ($urandom_range(0, 11) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));
      case ($urandom_range(0, 6))
         0: scap = '0;
         1: scap = 16'd1;
         2: scap = 16'd2;
         3: scap = 16'($urandom_range(3, 12));
         4: scap = '1;
         default: scap = STR_CAP_RST;
      endcase
      case ($urandom_range(0, 6))
         0: acap = '0;
         1: acap = 11'd1;
         2: acap = 11'($urandom_range(2, 6));
         3: acap = 11'd1024;
         4: acap = '1;
         default: acap = ARR_CAP_RST;
      endcase
      feed_odds = quiet ? 0 : pick_odds();
      sink_odds = quiet ? 0 : pick_odds();
      program_regs(kl, klo, khi, mode, scap, acap);
      @(negedge clock);
      repeat ($urandom_range(3, 8)) begin
         make_body();
         send_body();
      end
      settle();
   endtask

   initial begin
      restart_body();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      feed_odds = 6;
      sink_odds = 6;
      @(negedge clock);

      // reset key is one NUL byte: string ending on a lone backslash
      body_buf.delete();
      put_byte(CH_QUOTE);
      put_byte(8'h00);
      put_byte(CH_QUOTE);
      put_byte(CH_COLON);
      put_byte(CH_QUOTE);
      put_byte(CH_BSLASH);
      send_body();
      settle();

      // number closed by end of body, whitespace before colon
      program_regs(5'd1, 64'h6B, '1, MODE_U32, '1, 11'd1);
      @(negedge clock);
      body_buf.delete();
      put_text("\"k\" :\t7");
      send_body();
      settle();

      // second element hits array capacity
      program_regs(5'd1, 64'h6B, '0, MODE_ARRAY, 16'd1, 11'd1);
      @(negedge clock);
      body_buf.delete();
      put_text("\"k\":[5,6]");
      send_body();
      settle();

      // escaped tab, then string capacity, then ignored tail
      program_regs(5'd1, 64'h6B, '0, MODE_STRING, 16'd2, '0);
      @(negedge clock);
      body_buf.delete();
      put_text("\"k\":\"\\tz\"}");
      send_body();
      settle();

      while (bytes_sent < ITEM_TARGET - 150) random_phase(1'b0);
      random_phase(1'b1);
      random_phase(1'b1);
      repeat (16) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // input driver
   always @(posedge clock) begin
      body_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) step_extractor(req_data_byte, req_last_byte);
         if (!req_valid || !req_stall) begin
            if (feed_gap > 0) begin
               feed_gap--;
               req_valid <= 1'b0;
            end else if (feed_odds != 0 && $urandom_range(1, feed_odds) == 1) begin
               feed_gap = $urandom_range(0, 9);
               req_valid <= 1'b0;
            end else if (byte_feed.size() != 0) begin
               nxt = byte_feed.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= nxt.data;
               req_last_byte <= nxt.eob;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      jkv_result_type got;
      jkv_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_item_kind, rsp_item_value, rsp_result_status, rsp_end_of_run};
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected item: kind=%0d value=%0d status=%0d end=%0b",
                           got.kind, got.value, got.status, got.run_end);
            end else begin
               want = pending_results.pop_front();
               if (got.kind !== want.kind || got.value !== want.value ||
                   got.status !== want.status || got.run_end !== want.run_end) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("mismatch: exp kind=%0d value=%0d status=%0d end=%0b, %s",
                              want.kind, want.value, want.status, want.run_end,
                              $sformatf("got kind=%0d value=%0d status=%0d end=%0b",
                                        got.kind, got.value, got.status, got.run_end));
               end
            end
         end
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_stall <= 1'b1;
         end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
            sink_gap = $urandom_range(0, 9);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule
